>>> src/bib_pkg.sv
// bib_pkg: shared types and constants for the box IoU best-match block.
// Op codes, controller state type and controller/datapath command and status structs.
// No dependencies.
package bib_pkg;

    localparam int OP_W    = 2;
    localparam int CLASS_W = 8;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic scan_done;
        logic div_done;
    } t_status;

endpackage

>>> src/bib_if.sv
// bib_if: valid/ready channel interfaces for the box IoU best-match block.
// bib_in_if carries one input item, bib_out_if one result item.
// Depends on bib_pkg.
interface bib_in_if #(
    parameter int COORD_W = 13
);
    import bib_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [COORD_W-1:0]   x_min;
    logic [COORD_W-1:0]   y_min;
    logic [COORD_W-1:0]   x_max;
    logic [COORD_W-1:0]   y_max;
    logic [CLASS_W-1:0]   gt_class;

    modport source (output valid, op, x_min, y_min, x_max, y_max, gt_class, input ready);
    modport sink   (input valid, op, x_min, y_min, x_max, y_max, gt_class, output ready);
endinterface

interface bib_out_if #(
    parameter int IDX_W = 6,
    parameter int OVL_W = 17
);
    import bib_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     best_index;
    logic [CLASS_W-1:0]   best_class;
    logic [OVL_W-1:0]     overlap;
    logic                 no_gt;

    modport source (output valid, best_index, best_class, overlap, no_gt, input ready);
    modport sink   (input valid, best_index, best_class, overlap, no_gt, output ready);
endinterface

>>> src/bib_div.sv
// bib_div: restoring divider, one quotient bit per cycle, numerator <= denominator.
// Produces floor(num * 2^(Q_W-1) / den).
// Standalone; used by bib_datapath.
module bib_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 28,
    parameter int Q_W   = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_first;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= DEN_W'(i_num);
            r_den   <= i_den;
            r_quot  <= '0;
            r_first <= 1'b1;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_quot  <= {r_quot[Q_W-2:0], ge};
            r_first <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> src/bib_datapath.sv
// bib_datapath: box table memory, scan pipeline, best-overlap tracker, output register.
// Driven by bib_ctrl through t_cmd; reports through t_status.
// Depends on bib_pkg and bib_div.
module bib_datapath #(
    parameter int MAX_GT     = 64,
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16,
    parameter int IDX_W      = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bib_pkg::t_cmd                 i_cmd,
    output bib_pkg::t_status              o_status,
    input  logic [COORD_BITS-1:0]         i_x_min,
    input  logic [COORD_BITS-1:0]         i_y_min,
    input  logic [COORD_BITS-1:0]         i_x_max,
    input  logic [COORD_BITS-1:0]         i_y_max,
    input  logic [bib_pkg::CLASS_W-1:0]   i_gt_class,
    output logic [IDX_W-1:0]              o_best_index,
    output logic [bib_pkg::CLASS_W-1:0]   o_best_class,
    output logic [FRAC_BITS:0]            o_overlap,
    output logic                          o_no_gt
);
    import bib_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int EXT_W  = C + 1;
    localparam int MUL_W  = 2 * EXT_W;
    localparam int AREA_W = 2 * C + 1;
    localparam int UNI_W  = 2 * C + 2;
    localparam int PROD_W = AREA_W + UNI_W;
    localparam int OVL_W  = FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(MAX_GT + 1);
    localparam int ENT_W  = 4 * C + CLASS_W;

    function automatic logic [EXT_W-1:0] f_extent(input logic [C-1:0] lo,
                                                  input logic [C-1:0] hi);
        return (hi >= lo) ? ({1'b0, hi} - {1'b0, lo} + EXT_W'(1)) : '0;
    endfunction

    function automatic logic [AREA_W-1:0] f_area(input logic [EXT_W-1:0] a,
                                                 input logic [EXT_W-1:0] b);
        logic [MUL_W-1:0] p;
        p = MUL_W'(a) * MUL_W'(b);
        return p[AREA_W-1:0];
    endfunction

    // table
    logic [ENT_W-1:0]   r_mem [MAX_GT];
    logic [CNT_W-1:0]   r_count;

    // query box
    logic [C-1:0]       r_qx0, r_qy0, r_qx1, r_qy1;
    logic [AREA_W-1:0]  r_qarea;
    logic               r_nogt;

    // scan pipeline
    logic               r_scan;
    logic               r_first;
    logic [CNT_W-1:0]   r_rd_addr;
    logic               issue;
    logic [ENT_W-1:0]   r_rd_data;
    logic               r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]   r_idx1, r_idx2, r_idx3;
    logic [CLASS_W-1:0] r_cls2, r_cls3;
    logic [AREA_W-1:0]  r_inter2, r_garea2, r_inter3;
    logic [UNI_W-1:0]   r_uni3;

    // best tracker
    logic [IDX_W-1:0]   r_best_idx;
    logic [CLASS_W-1:0] r_best_cls;
    logic [AREA_W-1:0]  r_best_i;
    logic [UNI_W-1:0]   r_best_u;

    // output register
    logic [IDX_W-1:0]   r_o_idx;
    logic [CLASS_W-1:0] r_o_cls;
    logic [OVL_W-1:0]   r_o_ovl;
    logic               r_o_nogt;

    logic [C-1:0]       gx0, gy0, gx1, gy1;
    logic [CLASS_W-1:0] gcls;
    logic [C-1:0]       il, ir, it, ib;
    logic [AREA_W-1:0]  inter1, garea1;
    logic [UNI_W-1:0]   uni2;
    logic [PROD_W-1:0]  p_new, p_best;
    logic               win;
    logic               div_done;
    logic [OVL_W-1:0]   quot;

    assign issue = r_scan && (r_rd_addr != r_count);

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count != CNT_W'(MAX_GT))) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_gt_class, i_y_max, i_x_max, i_y_min, i_x_min};
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_addr[IDX_W-1:0]];
        end
    end

    // stage 1: intersection and stored-box area
    always_comb begin
        gx0  = r_rd_data[C-1:0];
        gy0  = r_rd_data[2*C-1:C];
        gx1  = r_rd_data[3*C-1:2*C];
        gy1  = r_rd_data[4*C-1:3*C];
        gcls = r_rd_data[ENT_W-1:4*C];
        il   = (r_qx0 > gx0) ? r_qx0 : gx0;
        ir   = (r_qx1 < gx1) ? r_qx1 : gx1;
        it   = (r_qy0 > gy0) ? r_qy0 : gy0;
        ib   = (r_qy1 < gy1) ? r_qy1 : gy1;
        inter1 = f_area(f_extent(il, ir), f_extent(it, ib));
        garea1 = f_area(f_extent(gx0, gx1), f_extent(gy0, gy1));
    end

    // stage 2: union, forced to one when both areas are empty
    always_comb begin
        uni2 = UNI_W'(r_qarea) + UNI_W'(r_garea2) - UNI_W'(r_inter2);
        if (uni2 == '0) begin
            uni2 = UNI_W'(1);
        end
    end

    // stage 3: cross-multiplied compare against the running best
    always_comb begin
        p_new  = PROD_W'(r_inter3) * PROD_W'(r_best_u);
        p_best = PROD_W'(r_best_i) * PROD_W'(r_uni3);
        win    = r_first || (p_new > p_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_scan    <= 1'b0;
            r_first   <= 1'b0;
            r_rd_addr <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load && (r_count != CNT_W'(MAX_GT))) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.start) begin
                r_scan    <= (r_count != '0);
                r_first   <= 1'b1;
                r_rd_addr <= '0;
            end else begin
                if (i_cmd.div_start) begin
                    r_scan <= 1'b0;
                end
                if (issue) begin
                    r_rd_addr <= r_rd_addr + CNT_W'(1);
                end
                if (r_v3) begin
                    r_first <= 1'b0;
                end
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qx0   <= i_x_min;
            r_qy0   <= i_y_min;
            r_qx1   <= i_x_max;
            r_qy1   <= i_y_max;
            r_qarea <= f_area(f_extent(i_x_min, i_x_max), f_extent(i_y_min, i_y_max));
            r_nogt  <= (r_count == '0);
        end
        r_idx1   <= r_rd_addr[IDX_W-1:0];
        r_idx2   <= r_idx1;
        r_cls2   <= gcls;
        r_inter2 <= inter1;
        r_garea2 <= garea1;
        r_idx3   <= r_idx2;
        r_cls3   <= r_cls2;
        r_inter3 <= r_inter2;
        r_uni3   <= uni2;
        if (r_v3 && win) begin
            r_best_idx <= r_idx3;
            r_best_cls <= r_cls3;
            r_best_i   <= r_inter3;
            r_best_u   <= r_uni3;
        end
        if (i_cmd.out_load) begin
            r_o_nogt <= r_nogt;
            r_o_idx  <= r_nogt ? '0 : r_best_idx;
            r_o_cls  <= (r_nogt || (r_best_i == '0)) ? '0 : r_best_cls;
            r_o_ovl  <= r_nogt ? '0 : quot;
        end
    end

    bib_div #(
        .NUM_W (AREA_W),
        .DEN_W (UNI_W),
        .Q_W   (OVL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_best_i),
        .i_den   (r_best_u),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign o_status.empty     = (r_count == '0);
    assign o_status.scan_done = r_scan && !issue && !r_v1 && !r_v2 && !r_v3;
    assign o_status.div_done  = div_done;

    assign o_best_index = r_o_idx;
    assign o_best_class = r_o_cls;
    assign o_overlap    = r_o_ovl;
    assign o_no_gt      = r_o_nogt;

endmodule

>>> src/bib_ctrl.sv
// bib_ctrl: sequencer for load, clear and query items and the result handshake.
// Issues t_cmd to bib_datapath and follows its t_status.
// Depends on bib_pkg.
module bib_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [bib_pkg::OP_W-1:0] i_op,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output bib_pkg::t_cmd            o_cmd,
    input  bib_pkg::t_status         i_status
);
    import bib_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_op == OP_QUERY)) begin
                    n_state = i_status.empty ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_LOAD:  o_cmd.load  = 1'b1;
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        OP_QUERY: o_cmd.start = 1'b1;
                        default:  o_cmd = '0;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.div_start = i_status.scan_done;
            end
            ST_DIV: begin
                o_cmd = '0;
            end
            ST_FINISH: begin
                o_cmd.out_load = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_query_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_op == OP_QUERY))
        |=> (r_state == ST_SCAN || r_state == ST_FINISH))
        else $error("query did not start a scan");

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.scan_done |-> (r_state == ST_SCAN))
        else $error("scan done outside scan");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide phase");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result raised outside finish");

endmodule

>>> src/box_iou_best_match.sv
// Box IoU best-match: a query scans the N stored boxes (one table read per cycle),
// runs the bit-serial divider on the best overlap, then loads the output register.
// A query on an empty table skips scan and divide and goes straight to the output register.
// One query is in work at a time; a waiting result does not block load or clear items,
// but a query holds its result back until the waiting one has been taken.
// Reset (synchronous, active low) empties the table; table contents are not cleared.
module box_iou_best_match #(
    parameter int MAX_GT     = 64,
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bib_in_if.sink    i_in,
    bib_out_if.source o_out
);
    import bib_pkg::*;

    localparam int IDX_W = (MAX_GT > 1) ? $clog2(MAX_GT) : 1;

    t_cmd    cmd;
    t_status status;

    bib_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    bib_datapath #(
        .MAX_GT     (MAX_GT),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .IDX_W      (IDX_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_x_min      (i_in.x_min),
        .i_y_min      (i_in.y_min),
        .i_x_max      (i_in.x_max),
        .i_y_max      (i_in.y_max),
        .i_gt_class   (i_in.gt_class),
        .o_best_index (o_out.best_index),
        .o_best_class (o_out.best_class),
        .o_overlap    (o_out.overlap),
        .o_no_gt      (o_out.no_gt)
    );

endmodule
